// ===== sv/rgbp_pkg.sv =====
// Shared types, constants and helper functions for the radix group byte packer.
package rgbp_pkg;

    // Widths fixed by the field definitions
    localparam int COEFF_W   = 16;
    localparam int GSIZE_W   = 3;
    localparam int GBITS_W   = 7;
    localparam int VALUE_W   = 64;
    localparam int BYTE_W    = 8;
    // Bit buffer in the back end: up to 7 carried bits plus a 64-bit group
    localparam int BUF_W     = VALUE_W + BYTE_W - 1;
    localparam int CFG_IDX_W = 2;

    localparam int MAX_GROUP_SIZE      = 4;
    localparam int DEF_QUEUE_DEPTH     = 2;
    localparam logic [COEFF_W-1:0] RST_MODULUS    = 16'd12289;
    localparam logic [GSIZE_W-1:0] RST_GROUP_SIZE = 3'd4;
    localparam logic [GBITS_W-1:0] RST_GROUP_BITS = 7'd55;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODULUS    = 2'd0,
        CFG_GROUP_SIZE = 2'd1,
        CFG_GROUP_BITS = 2'd2
    } t_cfg_idx;

    // One closed group handed from front to back
    typedef struct packed {
        logic               last;
        logic [VALUE_W-1:0] value;
    } t_grp;

    // Group size: 0 acts as 1, above the maximum acts as the maximum
    function automatic logic [GSIZE_W-1:0] clamp_k(input logic [GSIZE_W-1:0] k);
        logic [GSIZE_W-1:0] r;
        r = k;
        if (k == '0) begin
            r = GSIZE_W'(1);
        end else if (k > GSIZE_W'(MAX_GROUP_SIZE)) begin
            r = GSIZE_W'(MAX_GROUP_SIZE);
        end
        return r;
    endfunction

    // Group bits: 0 acts as 1, above 64 acts as 64
    function automatic logic [GBITS_W-1:0] clamp_gb(input logic [GBITS_W-1:0] gb);
        logic [GBITS_W-1:0] r;
        r = gb;
        if (gb == '0) begin
            r = GBITS_W'(1);
        end else if (gb > GBITS_W'(VALUE_W)) begin
            r = GBITS_W'(VALUE_W);
        end
        return r;
    endfunction

    // Mask keeping the low gb bits (gb already clamped to 1..64)
    function automatic logic [VALUE_W-1:0] low_mask(input logic [GBITS_W-1:0] gb);
        logic [VALUE_W-1:0] r;
        if (gb == GBITS_W'(VALUE_W)) begin
            r = '1;
        end else begin
            r = (VALUE_W'(1) << gb[5:0]) - VALUE_W'(1);
        end
        return r;
    endfunction

endpackage

// ===== sv/rgbp_front.sv =====
// Front end: accepts coefficients and folds them into radix groups.
module rgbp_front
    import rgbp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [COEFF_W-1:0] i_coeff,
    input  logic               i_last,
    input  logic [COEFF_W-1:0] i_modulus,
    input  logic [GSIZE_W-1:0] i_group_k,
    input  logic [VALUE_W-1:0] i_mask,
    input  logic               i_full,
    output logic               o_push,
    output t_grp               o_grp
);

    logic                r_mul_vld;
    logic [47:0]         r_plo;
    logic [31:0]         r_phi;
    logic [COEFF_W-1:0]  r_coeff;
    logic                r_last;
    logic [VALUE_W-1:0]  r_gv;
    logic [GSIZE_W-1:0]  r_dcnt;

    logic                accept;
    logic [47:0]         w_plo;
    logic [47:0]         w_phi;
    logic [VALUE_W-1:0]  sum;
    logic [GSIZE_W-1:0]  dcnt_inc;
    logic                close;

    // One word at a time: the product stage must fold in before the next, and no word is taken while the queue is full
    assign o_ready = !r_mul_vld && !i_full;
    assign accept  = i_valid && o_ready;

    // Split 64x16 multiply, only low 64 bits of the product are kept
    assign w_plo = {16'b0, r_gv[31:0]} * {32'b0, i_modulus};
    assign w_phi = {16'b0, r_gv[63:32]} * {32'b0, i_modulus};

    assign sum      = {16'b0, r_plo} + {r_phi, 32'b0} + {48'b0, r_coeff};
    assign dcnt_inc = r_dcnt + GSIZE_W'(1);
    assign close    = r_mul_vld && ((dcnt_inc >= i_group_k) || r_last);

    assign o_push      = close;
    assign o_grp.last  = r_last;
    assign o_grp.value = sum & i_mask;

    // Product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_vld <= 1'b0;
        end else begin
            r_mul_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_plo   <= w_plo;
            r_phi   <= w_phi[31:0];
            r_coeff <= i_coeff;
            r_last  <= i_last;
        end
    end

    // Accumulate stage: open group value and digit count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gv   <= '0;
            r_dcnt <= '0;
        end else if (r_mul_vld) begin
            if (close) begin
                r_gv   <= '0;
                r_dcnt <= '0;
            end else begin
                r_gv   <= sum;
                r_dcnt <= dcnt_inc;
            end
        end
    end

`ifndef SYNTH
    // An open group never reaches the largest group size
    a_dcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dcnt < GSIZE_W'(MAX_GROUP_SIZE))
        else $error("open group holds too many digits");
`endif

endmodule

// ===== sv/rgbp_queue.sv =====
// Short queue of closed groups between front and back.
module rgbp_queue
    import rgbp_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH  // power of two, 2 or more
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_grp i_grp,
    output logic o_full,
    output logic o_valid,
    output t_grp o_grp,
    input  logic i_pop
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_grp          r_mem [DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_grp   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + PW'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_grp;
        end
    end

`ifndef SYNTH
    // A closed group must never meet a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("group pushed into full queue");
`endif

endmodule

// ===== sv/rgbp_back.sv =====
// Back end: merges group bits into the byte stream and emits bytes.
module rgbp_back
    import rgbp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [GBITS_W-1:0] i_gb,
    input  logic               i_grp_valid,
    input  t_grp               i_grp,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [BYTE_W-1:0]  o_byte,
    output logic               o_last
);

    logic [BUF_W-1:0]   r_buf;
    logic [GBITS_W-1:0] r_cnt;
    logic               r_last;
    logic               r_ovld;
    logic [BYTE_W-1:0]  r_obyte;
    logic               r_olast;

    logic [BUF_W-1:0]   n_buf;
    logic [GBITS_W-1:0] n_cnt;
    logic               n_last;
    logic               n_ovld;

    logic               has_out;
    logic               slot_free;
    logic               emit;
    logic               load;

    // A byte is due when 8 bits are buffered, or any bits at end of vector
    assign has_out   = (r_cnt >= GBITS_W'(BYTE_W)) || (r_last && (r_cnt != '0));
    assign slot_free = !r_ovld || i_ready;
    assign emit      = has_out && slot_free;
    assign load      = !has_out && i_grp_valid;
    assign o_pop     = load;

    assign o_valid = r_ovld;
    assign o_byte  = r_obyte;
    assign o_last  = r_olast;

    // Buffer next state: shift out a byte, or append a new group above the carry
    always_comb begin
        n_buf  = r_buf;
        n_cnt  = r_cnt;
        n_last = r_last;
        if (emit) begin
            n_buf = r_buf >> BYTE_W;
            if (r_cnt >= GBITS_W'(BYTE_W)) begin
                n_cnt = r_cnt - GBITS_W'(BYTE_W);
            end else begin
                n_cnt = '0;
            end
        end else if (load) begin
            n_buf  = {{(BUF_W - BYTE_W + 1){1'b0}}, r_buf[BYTE_W-2:0]}
                   | ({{(BYTE_W - 1){1'b0}}, i_grp.value} << r_cnt[2:0]);
            n_cnt  = {{(GBITS_W - 3){1'b0}}, r_cnt[2:0]} + i_gb;
            n_last = i_grp.last;
        end
    end

    // Output word register
    always_comb begin
        n_ovld = r_ovld;
        if (emit) begin
            n_ovld = 1'b1;
        end else if (i_ready) begin
            n_ovld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf  <= '0;
            r_cnt  <= '0;
            r_last <= 1'b0;
            r_ovld <= 1'b0;
        end else begin
            r_buf  <= n_buf;
            r_cnt  <= n_cnt;
            r_last <= n_last;
            r_ovld <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_obyte <= r_buf[BYTE_W-1:0];
            r_olast <= r_last && (r_cnt <= GBITS_W'(BYTE_W));
        end
    end

`ifndef SYNTH
    // Buffered bit count stays within the buffer
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= GBITS_W'(BUF_W))
        else $error("bit buffer overfilled");

    // Loading a group always adds bits to the buffer
    a_load_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> r_cnt > $past(r_cnt))
        else $error("group load added no bits");

    // An emitted byte marked last leaves no bits behind
    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && r_last && (r_cnt <= GBITS_W'(BYTE_W))) |=> (r_cnt == '0))
        else $error("bits left after last byte");
`endif

endmodule

// ===== sv/radix_group_byte_packer_core.sv =====
// Path: a group-closing coefficient passes the product stage, queue, back-end bit buffer and
// output byte register; later bytes of the group follow one per cycle while the output is ready.
// Flow: a coefficient is taken only once the previous one has left the product stage (the split
// multiply-accumulate loop) and the queue is not full; the byte side pauses to load each group.
// Reset: synchronous, active low; clears all group, carry and queue state and returns the
// registers to modulus 12289, group size 4, group bits 55.
module radix_group_byte_packer_core
    import rgbp_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Coefficient stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [COEFF_W-1:0]   s_axis_tdata,   // [15:0] coeff
    input  logic                 s_axis_tlast,   // last_coeff
    // Byte stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [BYTE_W-1:0]    m_axis_tdata,   // [7:0] out_byte
    output logic                 m_axis_tlast,   // last_byte
    // Register writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [COEFF_W-1:0]   i_cfg_data
);

    logic [COEFF_W-1:0] r_modulus;
    logic [GSIZE_W-1:0] r_group_size;
    logic [GBITS_W-1:0] r_group_bits;

    logic [GSIZE_W-1:0] group_k;
    logic [GBITS_W-1:0] group_gb;
    logic [VALUE_W-1:0] group_mask;

    logic push;
    t_grp push_grp;
    logic q_full;
    logic q_valid;
    t_grp q_grp;
    logic pop;

    // Register file
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus    <= RST_MODULUS;
            r_group_size <= RST_GROUP_SIZE;
            r_group_bits <= RST_GROUP_BITS;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_MODULUS:    r_modulus    <= i_cfg_data;
                CFG_GROUP_SIZE: r_group_size <= i_cfg_data[GSIZE_W-1:0];
                CFG_GROUP_BITS: r_group_bits <= i_cfg_data[GBITS_W-1:0];
                default: ;
            endcase
        end
    end

    assign group_k    = clamp_k(r_group_size);
    assign group_gb   = clamp_gb(r_group_bits);
    assign group_mask = low_mask(group_gb);

    rgbp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_coeff   (s_axis_tdata),
        .i_last    (s_axis_tlast),
        .i_modulus (r_modulus),
        .i_group_k (group_k),
        .i_mask    (group_mask),
        .i_full    (q_full),
        .o_push    (push),
        .o_grp     (push_grp)
    );

    rgbp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_grp   (push_grp),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_grp   (q_grp),
        .i_pop   (pop)
    );

    rgbp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_gb        (group_gb),
        .i_grp_valid (q_valid),
        .i_grp       (q_grp),
        .o_pop       (pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_byte      (m_axis_tdata),
        .o_last      (m_axis_tlast)
    );

endmodule
